/* rtl/core/csv_name_generation_parser_macros.svh */
// Assertion macros shared by the csv name/generation parser
`ifndef CSV_NAME_GENERATION_PARSER_MACROS_SVH
`define CSV_NAME_GENERATION_PARSER_MACROS_SVH

// same-cycle implication
`define CSVP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csv parser check failed");

// next-cycle implication
`define CSVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csv parser check failed");

`endif

/* rtl/core/csvp_pkg.sv */
// Package for the csv name/generation parser: types, codes and constants
package csvp_pkg;

   localparam int NAME_LIMIT_DEFAULT        = 32;
   localparam int NUMBER_CHAR_LIMIT_DEFAULT = 16;

   localparam int CHAR_W  = 8;
   localparam int ENTRY_W = 12;
   localparam int GEN_W   = 32;
   localparam int VAL_W   = GEN_W + 1;

   localparam logic [ENTRY_W-1:0] ENTRY_LIMIT_RESET = 12'd4095;
   localparam logic [VAL_W-1:0]   VALUE_CAP         = 33'h1_0000_0000;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_VTAB  = 8'h0B;
   localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_GEN   = 2'd1,
      KIND_COUNT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FLD_NAME   = 2'd0,
      FLD_NUMBER = 2'd1,
      FLD_SKIP   = 2'd2
   } field_type;

   typedef enum logic [1:0] {
      NUM_SPACE  = 2'd0,
      NUM_SIGN   = 2'd1,
      NUM_DIGITS = 2'd2
   } num_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_NAME  = 2'd1,
      ST_GEN   = 2'd2,
      ST_COUNT = 2'd3
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     load;
      kind_type kind;
      logic     run_end;
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic last;
      logic name_end;
   } status_type;

endpackage

/* rtl/core/csvp_ctrl.sv */
// Controller: input handshake, result sequencing and output valid
`include "csv_name_generation_parser_macros.svh"

module csvp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  csvp_pkg::status_type status,
   output csvp_pkg::cmd_type    cmd
);
   import csvp_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      pend_in     = pend_ff;
      cmd.accept  = accept;
      cmd.load    = 1'b0;
      cmd.kind    = KIND_NAME;
      cmd.run_end = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in = status.last;
               if (status.keep) begin
                  state_in = ST_NAME;
               end else if (status.last) begin
                  state_in = ST_COUNT;
               end
            end
         end
         ST_NAME: begin
            cmd.kind = KIND_NAME;
            if (out_free) begin
               cmd.load = 1'b1;
               if (status.name_end) begin
                  state_in = ST_GEN;
               end
            end
         end
         ST_GEN: begin
            cmd.kind    = KIND_GEN;
            cmd.run_end = !pend_ff;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = pend_ff ? ST_COUNT : ST_IDLE;
            end
         end
         ST_COUNT: begin
            cmd.kind    = KIND_COUNT;
            cmd.run_end = 1'b1;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   `CSVP_ASSERT_NEXT(a_keep_to_name, clock, reset, accept && status.keep, state_ff == ST_NAME)
   `CSVP_ASSERT_NEXT(a_last_to_count, clock, reset,
      accept && status.last && !status.keep, state_ff == ST_COUNT)
   `CSVP_ASSERT_NEXT(a_run_end_idle, clock, reset,
      cmd.load && cmd.run_end, state_ff == ST_IDLE && rsp_valid_ff)

endmodule

/* rtl/core/csvp_dp.sv */
// Datapath: line parser, name store, held results and output payload register
module csvp_dp #(
   parameter int NAME_LIMIT        = csvp_pkg::NAME_LIMIT_DEFAULT,
   parameter int NUMBER_CHAR_LIMIT = csvp_pkg::NUMBER_CHAR_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [csvp_pkg::CHAR_W-1:0]   req_char_byte,
   input  logic                          req_last_byte,
   input  logic                          csr_write_en,
   input  logic [csvp_pkg::ENTRY_W-1:0]  csr_write_data,
   input  csvp_pkg::cmd_type             cmd,
   output csvp_pkg::status_type          status,
   output logic [1:0]                    rsp_kind,
   output logic [csvp_pkg::CHAR_W-1:0]   rsp_name_byte,
   output logic [csvp_pkg::GEN_W-1:0]    rsp_generation,
   output logic [csvp_pkg::ENTRY_W-1:0]  rsp_entry_index,
   output logic [csvp_pkg::ENTRY_W-1:0]  rsp_entry_count,
   output logic                          rsp_run_end
);
   import csvp_pkg::*;

   localparam int NAME_DEPTH = NAME_LIMIT - 1;
   localparam int IDX_W      = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
   localparam int LEN_W      = $clog2(NAME_LIMIT + 1);
   localparam int CHR_W      = $clog2(NUMBER_CHAR_LIMIT + 2);
   localparam int MUL_W      = VAL_W + 4;

   logic [CHAR_W-1:0] name_mem [NAME_DEPTH];

   logic [LEN_W-1:0]   len_ff, len_in;
   field_type          field_ff, field_in;
   num_type            nphase_ff, nphase_in;
   logic [CHR_W-1:0]   chars_ff, chars_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic               neg_ff, neg_in;
   logic               bad_ff, bad_in;
   logic [ENTRY_W-1:0] cnt_ff, cnt_in;
   logic               halted_ff, halted_in;
   logic [ENTRY_W-1:0] max_ff;

   logic [LEN_W-1:0]   emit_len_ff;
   logic [GEN_W-1:0]   gen_hold_ff;
   logic [ENTRY_W-1:0] idx_hold_ff;
   logic [ENTRY_W-1:0] cnt_hold_ff;
   logic [LEN_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CHAR_W-1:0]  rdata_ff;

   kind_type           kind_ff;
   logic [CHAR_W-1:0]  name_byte_ff;
   logic [GEN_W-1:0]   gen_ff;
   logic [ENTRY_W-1:0] idx_ff;
   logic [ENTRY_W-1:0] count_ff;
   logic               run_end_ff;

   logic [LEN_W-1:0]   f_len;
   field_type          f_field;
   num_type            f_nphase;
   logic [CHR_W-1:0]   f_chars;
   logic [VAL_W-1:0]   f_val;
   logic               f_neg;
   logic               f_bad;
   logic               is_term, is_digit, is_space, is_comma;
   logic               do_feed, do_finish, mem_we, ok, keep;
   logic [3:0]         digit;
   logic [MUL_W-1:0]   val_x10;
   logic [ENTRY_W-1:0] cnt_after;

   assign is_term  = (req_char_byte == CHAR_LF) || (req_char_byte == CHAR_CR) ||
                     (req_char_byte == CHAR_NUL);
   assign is_digit = (req_char_byte >= CHAR_ZERO) && (req_char_byte <= CHAR_NINE);
   assign is_space = (req_char_byte == CHAR_SPACE) || (req_char_byte == CHAR_TAB) ||
                     (req_char_byte == CHAR_VTAB) || (req_char_byte == CHAR_FF);
   assign is_comma = (req_char_byte == CHAR_COMMA);
   assign digit    = 4'(req_char_byte - CHAR_ZERO);
   assign val_x10  = ({4'b0, val_ff} << 3) + ({4'b0, val_ff} << 1) + MUL_W'(digit);

   assign do_feed   = !halted_ff && !is_term;
   assign do_finish = !halted_ff && (is_term || req_last_byte);
   assign mem_we    = cmd.accept && do_feed && (field_ff == FLD_NAME) && !is_comma &&
                      (len_ff < LEN_W'(NAME_DEPTH));

   always_comb begin
      f_len    = len_ff;
      f_field  = field_ff;
      f_nphase = nphase_ff;
      f_chars  = chars_ff;
      f_val    = val_ff;
      f_neg    = neg_ff;
      f_bad    = bad_ff;
      if (do_feed) begin
         unique case (field_ff)
            FLD_NAME: begin
               if (is_comma) begin
                  f_field = FLD_NUMBER;
               end else if (len_ff < LEN_W'(NAME_LIMIT)) begin
                  f_len = len_ff + 1'b1;
               end
            end
            FLD_NUMBER: begin
               if (is_comma) begin
                  f_field = FLD_SKIP;
               end else begin
                  if (chars_ff <= CHR_W'(NUMBER_CHAR_LIMIT)) begin
                     f_chars = chars_ff + 1'b1;
                  end
                  unique case (nphase_ff)
                     NUM_SPACE: begin
                        if (is_space) begin
                           f_nphase = nphase_ff;
                        end else if (req_char_byte == CHAR_PLUS) begin
                           f_nphase = NUM_SIGN;
                        end else if (req_char_byte == CHAR_MINUS) begin
                           f_neg    = 1'b1;
                           f_nphase = NUM_SIGN;
                        end else if (is_digit) begin
                           f_val    = VAL_W'(digit);
                           f_nphase = NUM_DIGITS;
                        end else begin
                           f_bad = 1'b1;
                        end
                     end
                     NUM_SIGN: begin
                        if (is_digit) begin
                           f_val    = VAL_W'(digit);
                           f_nphase = NUM_DIGITS;
                        end else begin
                           f_bad = 1'b1;
                        end
                     end
                     NUM_DIGITS: begin
                        if (is_digit) begin
                           f_val = (val_x10 > MUL_W'(VALUE_CAP)) ? VALUE_CAP
                                                                 : val_x10[VAL_W-1:0];
                        end else begin
                           f_bad = 1'b1;
                        end
                     end
                     default: begin
                        f_bad = 1'b1;
                     end
                  endcase
               end
            end
            default: begin
               f_field = field_ff;
            end
         endcase
      end

      ok = (f_field != FLD_NAME) &&
           (f_len >= LEN_W'(1)) && (f_len <= LEN_W'(NAME_DEPTH)) &&
           (f_chars >= CHR_W'(1)) && (f_chars <= CHR_W'(NUMBER_CHAR_LIMIT)) &&
           (f_nphase == NUM_DIGITS) && !f_bad && !f_val[VAL_W-1] &&
           !(f_neg && (f_val != '0)) && (cnt_ff < max_ff);
      keep      = do_finish && ok;
      cnt_after = keep ? cnt_ff + 1'b1 : cnt_ff;

      len_in    = len_ff;
      field_in  = field_ff;
      nphase_in = nphase_ff;
      chars_in  = chars_ff;
      val_in    = val_ff;
      neg_in    = neg_ff;
      bad_in    = bad_ff;
      cnt_in    = cnt_ff;
      halted_in = halted_ff;
      if (cmd.accept) begin
         if (do_finish || req_last_byte) begin
            len_in    = '0;
            field_in  = FLD_NAME;
            nphase_in = NUM_SPACE;
            chars_in  = '0;
            val_in    = '0;
            neg_in    = 1'b0;
            bad_in    = 1'b0;
         end else begin
            len_in    = f_len;
            field_in  = f_field;
            nphase_in = f_nphase;
            chars_in  = f_chars;
            val_in    = f_val;
            neg_in    = f_neg;
            bad_in    = f_bad;
         end
         if (req_last_byte) begin
            cnt_in    = '0;
            halted_in = 1'b0;
         end else begin
            cnt_in    = cnt_after;
            halted_in = halted_ff || (do_finish && (cnt_after >= max_ff)) ||
                        (!halted_ff && (req_char_byte == CHAR_NUL));
         end
      end

      if (cmd.accept) begin
         rd_ptr_in = '0;
      end else if (cmd.load && (cmd.kind == KIND_NAME)) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end else begin
         rd_ptr_in = rd_ptr_ff;
      end
   end

   assign status.keep     = keep;
   assign status.last     = req_last_byte;
   assign status.name_end = ((rd_ptr_ff + 1'b1) == emit_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         field_ff  <= FLD_NAME;
         nphase_ff <= NUM_SPACE;
         chars_ff  <= '0;
         val_ff    <= '0;
         neg_ff    <= 1'b0;
         bad_ff    <= 1'b0;
         cnt_ff    <= '0;
         halted_ff <= 1'b0;
         max_ff    <= ENTRY_LIMIT_RESET;
         rd_ptr_ff <= '0;
      end else begin
         len_ff    <= len_in;
         field_ff  <= field_in;
         nphase_ff <= nphase_in;
         chars_ff  <= chars_in;
         val_ff    <= val_in;
         neg_ff    <= neg_in;
         bad_ff    <= bad_in;
         cnt_ff    <= cnt_in;
         halted_ff <= halted_in;
         rd_ptr_ff <= rd_ptr_in;
         if (csr_write_en) begin
            max_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[len_ff[IDX_W-1:0]] <= req_char_byte;
      end
      if (rd_ptr_in < LEN_W'(NAME_DEPTH)) begin
         rdata_ff <= name_mem[rd_ptr_in[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         emit_len_ff <= f_len;
         gen_hold_ff <= f_val[GEN_W-1:0];
         idx_hold_ff <= cnt_ff;
         cnt_hold_ff <= cnt_after;
      end
      if (cmd.load) begin
         kind_ff      <= cmd.kind;
         name_byte_ff <= (cmd.kind == KIND_NAME) ? rdata_ff : '0;
         gen_ff       <= (cmd.kind == KIND_GEN) ? gen_hold_ff : '0;
         idx_ff       <= (cmd.kind == KIND_COUNT) ? '0 : idx_hold_ff;
         count_ff     <= (cmd.kind == KIND_COUNT) ? cnt_hold_ff : '0;
         run_end_ff   <= cmd.run_end;
      end
   end

   assign rsp_kind        = kind_ff;
   assign rsp_name_byte   = name_byte_ff;
   assign rsp_generation  = gen_ff;
   assign rsp_entry_index = idx_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_run_end     = run_end_ff;

endmodule

/* rtl/core/csv_name_generation_parser.sv */
// Top level of the csv name/generation line parser
//
// Takes one text byte per item and parses name,generation lines. A line end
// that keeps an entry yields one result per name byte and then one for the
// generation, and a last byte adds a result for the count; the result output
// register emits one result a cycle while rsp_stall does not hold it, so that
// sequence of results sets the rate. Input is stalled while the results of an
// item are still being sequenced out. The user is to write the entry limit
// through csr_write_en/csr_write_data while idle; the block does not check.
module csv_name_generation_parser #(
   parameter int NAME_LIMIT        = csvp_pkg::NAME_LIMIT_DEFAULT,
   parameter int NUMBER_CHAR_LIMIT = csvp_pkg::NUMBER_CHAR_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csvp_pkg::CHAR_W-1:0]   req_char_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [csvp_pkg::CHAR_W-1:0]   rsp_name_byte,
   output logic [csvp_pkg::GEN_W-1:0]    rsp_generation,
   output logic [csvp_pkg::ENTRY_W-1:0]  rsp_entry_index,
   output logic [csvp_pkg::ENTRY_W-1:0]  rsp_entry_count,
   output logic                          rsp_run_end,
   input  logic                          csr_write_en,
   input  logic [csvp_pkg::ENTRY_W-1:0]  csr_write_data
);
   import csvp_pkg::*;

   cmd_type    cmd;
   status_type status;

   csvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   csvp_dp #(
      .NAME_LIMIT        (NAME_LIMIT),
      .NUMBER_CHAR_LIMIT (NUMBER_CHAR_LIMIT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_char_byte   (req_char_byte),
      .req_last_byte   (req_last_byte),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_kind        (rsp_kind),
      .rsp_name_byte   (rsp_name_byte),
      .rsp_generation  (rsp_generation),
      .rsp_entry_index (rsp_entry_index),
      .rsp_entry_count (rsp_entry_count),
      .rsp_run_end     (rsp_run_end)
   );

endmodule
